/* rtl/gdf_pkg.sv */
`timescale 1ns / 1ps

package gdf_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned NUM_W   = 15;
  localparam int unsigned QUO_W   = 8;

  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [15:0] MOD7_MUL     = 16'd37450;
  localparam int unsigned MOD7_SHIFT   = 18;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic       date_valid;
    logic [8:0] days_to_year_end;
    logic [4:0] days_to_month_end;
    logic [2:0] days_to_week_end;
    logic [4:0] month_length;
    logic       is_leap_year;
    logic       is_business_day;
    logic       is_weekend;
    logic       is_sunday;
    logic [2:0] weekday;
  } gdf_res_t;

  function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      MONTH_FEB:                                  d = 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // (31 * shifted month) / 12, March counted as month 1
  function automatic logic [4:0] month_shift(input logic [MONTH_W-1:0] m);
    logic [4:0] s;
    case (m)
      4'd1:    s = 5'd28;
      4'd2:    s = 5'd31;
      4'd3:    s = 5'd2;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd7;
      4'd6:    s = 5'd10;
      4'd7:    s = 5'd12;
      4'd8:    s = 5'd15;
      4'd9:    s = 5'd18;
      4'd10:   s = 5'd20;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd25;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

/* rtl/gregorian_date_facts_core.sv */
`timescale 1ns / 1ps

// Gregorian date facts: one date (year, month, day) goes in per word and one
// word of facts comes out: weekday (Sunday 0), Sunday/weekend/business-day
// flags, leap year, month length and the days left to Saturday, to month end
// (end day counted) and to 31 December (end day not counted). A date whose
// month or day is out of range comes back with date_valid low and all day
// counts and weekday flags zero; leap year and month length are still given.
// The block takes one date every clock while the output side is not stalled
// and has four register stages (input, quotient, sum, result); a result passes
// through them in that order to the output. Each stage advances on its own, so
// bubbles are squeezed out under back-pressure.
module gregorian_date_facts_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // year[13:0], month[17:14], day_of_month[22:18], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // weekday[2:0], is_sunday[3], is_weekend[4],
                                  // is_business_day[5], is_leap_year[6],
                                  // month_length[11:7], days_to_week_end[14:12],
                                  // days_to_month_end[19:15], days_to_year_end[28:20],
                                  // date_valid[29], zero pad
);
  import gdf_pkg::*;

  logic adv1, adv2, adv3, adv4;

  // stage 1: input register
  logic               v1_r;
  logic [YEAR_W-1:0]  year1_r;
  logic [MONTH_W-1:0] mon1_r;
  logic [DAY_W-1:0]   day1_r;

  // stage 2: quotients
  logic               v2_r;
  logic [YEAR_W-1:0]  year2_r;
  logic [MONTH_W-1:0] mon2_r;
  logic [DAY_W-1:0]   day2_r;
  logic [NUM_W-1:0]   ys2_r, ys_nxt;
  logic [QUO_W-1:0]   qs100_r, qs400_r, qy100_r, qy400_r;
  logic [QUO_W-1:0]   qs100_nxt, qs400_nxt, qy100_nxt, qy400_nxt;

  // stage 3: weekday sum, leap, validity
  logic               v3_r;
  logic [MONTH_W-1:0] mon3_r;
  logic [DAY_W-1:0]   day3_r;
  logic [NUM_W-1:0]   sum3_r, sum_nxt;
  logic               leap3_r, leap_nxt;
  logic [4:0]         mlen3_r, mlen_nxt;
  logic               valid3_r, valid_nxt;

  // stage 4: result register
  logic               v4_r;
  gdf_res_t           res_r, res_nxt;

  assign adv4      = !v4_r || out_tready;
  assign adv3      = !v3_r || adv4;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;

  // stage 1 -> 2
  logic a_shift;
  assign a_shift = (mon1_r <= MONTH_FEB);
  assign ys_nxt  = NUM_W'(year1_r) + NUM_W'(400) - NUM_W'(a_shift);

  gdf_div100 u_div_s100 (.num(ys_nxt),                 .quo(qs100_nxt));
  gdf_div100 u_div_s400 (.num(NUM_W'(ys_nxt >> 2)),    .quo(qs400_nxt));
  gdf_div100 u_div_y100 (.num(NUM_W'(year1_r)),        .quo(qy100_nxt));
  gdf_div100 u_div_y400 (.num(NUM_W'(year1_r >> 2)),   .quo(qy400_nxt));

  // stage 2 -> 3
  logic [YEAR_W-1:0] rem100;
  logic [YEAR_W-3:0] rem400;
  logic              mvalid;
  logic [4:0]        mbase;

  always_comb begin
    rem100   = year2_r - YEAR_W'(qy100_r) * YEAR_W'(7'd100);
    rem400   = year2_r[YEAR_W-1:2] - (YEAR_W-2)'(qy400_r) * (YEAR_W-2)'(7'd100);
    leap_nxt = (year2_r[1:0] == 2'b00) && ((rem100 != '0) || (rem400 == '0));
    mvalid   = (mon2_r >= 4'd1) && (mon2_r <= MONTH_DEC);
    mbase    = month_days(mon2_r);
    mlen_nxt = (mon2_r == MONTH_FEB && leap_nxt) ? 5'd29 : mbase;
    valid_nxt = mvalid && (day2_r != '0) && (day2_r <= mlen_nxt);
    sum_nxt  = NUM_W'(day2_r) + ys2_r + NUM_W'(ys2_r >> 2) - NUM_W'(qs100_r)
             + NUM_W'(qs400_r) + NUM_W'(month_shift(mon2_r));
  end

  // stage 3 -> 4
  logic [31:0] prod7;
  logic [11:0] q7;
  logic [2:0]  wd;
  logic [8:0]  doy;
  logic [8:0]  ylen;

  always_comb begin
    prod7 = 32'(sum3_r) * 32'(MOD7_MUL);
    q7    = 12'(prod7 >> MOD7_SHIFT);
    wd    = 3'(sum3_r - NUM_W'(q7) * NUM_W'(3'd7));
    doy   = days_before(mon3_r) + 9'(day3_r) + 9'(leap3_r && (mon3_r > MONTH_FEB));
    ylen  = leap3_r ? 9'd366 : 9'd365;
    res_nxt                   = '0;
    res_nxt.is_leap_year      = leap3_r;
    res_nxt.month_length      = mlen3_r;
    res_nxt.date_valid        = valid3_r;
    if (valid3_r) begin
      res_nxt.weekday           = wd;
      res_nxt.is_sunday         = (wd == 3'd0);
      res_nxt.is_weekend        = (wd == 3'd0) || (wd == 3'd6);
      res_nxt.is_business_day   = !((wd == 3'd0) || (wd == 3'd6));
      res_nxt.days_to_week_end  = 3'd6 - wd;
      res_nxt.days_to_month_end = mlen3_r - day3_r + 5'd1;
      res_nxt.days_to_year_end  = ylen - doy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_tvalid) begin
      year1_r <= in_tdata[13:0];
      mon1_r  <= in_tdata[17:14];
      day1_r  <= in_tdata[22:18];
    end
    if (adv2 && v1_r) begin
      year2_r <= year1_r;
      mon2_r  <= mon1_r;
      day2_r  <= day1_r;
      ys2_r   <= ys_nxt;
      qs100_r <= qs100_nxt;
      qs400_r <= qs400_nxt;
      qy100_r <= qy100_nxt;
      qy400_r <= qy400_nxt;
    end
    if (adv3 && v2_r) begin
      mon3_r   <= mon2_r;
      day3_r   <= day2_r;
      sum3_r   <= sum_nxt;
      leap3_r  <= leap_nxt;
      mlen3_r  <= mlen_nxt;
      valid3_r <= valid_nxt;
    end
    if (adv4 && v3_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {2'b00, res_r};

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res_r.date_valid |->
      res_r.weekday == '0 && res_r.days_to_month_end == '0 &&
      res_r.days_to_year_end == '0 && !res_r.is_business_day)
    else $error("invalid date gave nonzero facts");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.date_valid |->
      res_r.is_business_day == !res_r.is_weekend &&
      res_r.is_weekend == (res_r.weekday == 3'd0 || res_r.weekday == 3'd6) &&
      res_r.weekday <= 3'd6)
    else $error("weekday flags disagree");

  a_week_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.date_valid |->
      (res_r.days_to_week_end + res_r.weekday) == 3'd6)
    else $error("days to week end wrong");

  a_month_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.date_valid |->
      res_r.days_to_month_end != '0 && res_r.days_to_month_end <= res_r.month_length)
    else $error("days to month end out of range");

endmodule

/* rtl/gdf_div100.sv */
`timescale 1ns / 1ps

module gdf_div100 (
  input  logic [gdf_pkg::NUM_W-1:0] num,
  output logic [gdf_pkg::QUO_W-1:0] quo
);
  import gdf_pkg::*;

  logic [27:0] prod;

  assign prod = 28'(num) * 28'(DIV100_MUL);
  assign quo  = QUO_W'(prod >> DIV100_SHIFT);

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import gdf_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    bit                 typed;
    gdf_res_t           facts;
  } date_row_t;

  localparam int unsigned RANDOM_DATES = 1500;
  localparam int unsigned IDLE_PCT     = 26;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  date_row_t   date_rows[$];
  date_row_t   facts_q[$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;

  gregorian_date_facts_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_len(int unsigned y, int unsigned m);
    int unsigned n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 31;
      4, 6, 9, 11:           n = 30;
      MONTH_FEB:             n = leap_year(y) ? 29 : 28;
      default:               n = 0;
    endcase
    return n;
  endfunction

  function automatic gdf_res_t date_facts(int unsigned y, int unsigned m, int unsigned d);
    gdf_res_t    f;
    int unsigned mlen;
    int unsigned doy;
    int unsigned ys;
    int unsigned ms;
    int unsigned wd;
    int unsigned k;
    bit          lp;
    f    = '0;
    lp   = leap_year(y);
    mlen = month_len(y, m);
    f.is_leap_year = lp;
    f.month_length = mlen[4:0];
    if (d >= 1 && d <= mlen) begin
      doy = d;
      for (k = 1; k < m; k++) doy += month_len(y, k);
      // Jan and Feb count as months 11 and 12 of the previous year
      ys = y + 400 - ((m <= MONTH_FEB) ? 1 : 0);
      ms = (m <= MONTH_FEB) ? m + 10 : m - 2;
      wd = (d + ys + ys / 4 - ys / 100 + ys / 400 + (31 * ms) / 12) % 7;
      f.weekday           = wd[2:0];
      f.is_sunday         = (wd == 0);
      f.is_weekend        = (wd == 0) || (wd == 6);
      f.is_business_day   = (wd != 0) && (wd != 6);
      f.days_to_week_end  = 3'(6 - wd);
      f.days_to_month_end = 5'(mlen - d + 1);
      f.days_to_year_end  = 9'((lp ? 366 : 365) - doy);
      f.date_valid        = 1'b1;
    end
    return f;
  endfunction

  function automatic date_row_t make_row(int unsigned y, int unsigned m, int unsigned d);
    date_row_t r;
    r.year  = y[YEAR_W-1:0];
    r.month = m[MONTH_W-1:0];
    r.day   = d[DAY_W-1:0];
    r.typed = 1'b0;
    r.facts = '0;
    return r;
  endfunction

  task automatic add_date(int unsigned y, int unsigned m, int unsigned d);
    date_rows.push_back(make_row(y, m, d));
  endtask

  task automatic add_bad_date(int unsigned y, int unsigned m, int unsigned d,
                              bit lp, int unsigned mlen);
    date_row_t r;
    r = make_row(y, m, d);
    r.typed = 1'b1;
    r.facts.is_leap_year = lp;
    r.facts.month_length = mlen[4:0];
    date_rows.push_back(r);
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic field_check(date_row_t w, string name, int unsigned got, int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%0d-%0d-%0d %s got %0d want %0d",
                                w.year, w.month, w.day, name, got, want));
  endtask

  task automatic send_date(date_row_t r);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, r.day, r.month, r.year};
    do @(posedge clk); while (!in_tready);
    if (!r.typed) r.facts = date_facts(r.year, r.month, r.day);
    facts_q.push_back(r);
  endtask

  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    date_row_t w;
    gdf_res_t  got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[29:0];
      if (facts_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_tdata));
      end else begin
        w = facts_q.pop_front();
        field_check(w, "weekday", got.weekday, w.facts.weekday);
        field_check(w, "is_sunday", got.is_sunday, w.facts.is_sunday);
        field_check(w, "is_weekend", got.is_weekend, w.facts.is_weekend);
        field_check(w, "is_business_day", got.is_business_day, w.facts.is_business_day);
        field_check(w, "is_leap_year", got.is_leap_year, w.facts.is_leap_year);
        field_check(w, "month_length", got.month_length, w.facts.month_length);
        field_check(w, "days_to_week_end", got.days_to_week_end, w.facts.days_to_week_end);
        field_check(w, "days_to_month_end", got.days_to_month_end,
                    w.facts.days_to_month_end);
        field_check(w, "days_to_year_end", got.days_to_year_end, w.facts.days_to_year_end);
        field_check(w, "date_valid", got.date_valid, w.facts.date_valid);
        field_check(w, "pad", out_tdata[31:30], 0);
      end
    end
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned pick;
    int unsigned n;

    add_bad_date(2000, 0, 1, 1, 0);
    add_bad_date(2023, 13, 15, 0, 0);
    add_bad_date(16383, 15, 31, 0, 0);
    add_bad_date(2023, 1, 0, 0, 31);
    add_bad_date(2024, 4, 31, 1, 30);
    add_bad_date(2023, MONTH_FEB, 29, 0, 28);
    add_bad_date(1900, MONTH_FEB, 29, 0, 28);
    add_bad_date(0, 6, 31, 1, 30);
    add_date(1, 1, 1);
    add_date(9999, MONTH_DEC, 31);
    add_date(2024, MONTH_FEB, 29);
    add_date(2000, MONTH_FEB, 29);
    add_date(2400, MONTH_FEB, 29);
    add_date(10000, MONTH_FEB, 29);
    add_date(0, 1, 1);
    add_date(0, 3, 1);
    add_date(16383, MONTH_DEC, 31);
    add_date(2023, MONTH_DEC, 31);
    add_date(2024, MONTH_DEC, 31);
    add_date(2024, 1, 1);
    add_date(2023, MONTH_FEB, 28);
    add_date(2024, 3, 1);
    add_date(1900, 3, 1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (date_rows[i]) send_date(date_rows[i]);

    for (n = 0; n < RANDOM_DATES; n++) begin
      calm = (n >= 600 && n < 900);
      pick = $urandom_range(99);
      y = ($urandom_range(99) < 70) ? $urandom_range(9999, 1) : $urandom_range(16383, 0);
      m = $urandom_range(12, 1);
      if (pick < 70) begin
        d = $urandom_range(month_len(y, m), 1);
      end else if (pick < 85) begin
        case ($urandom_range(2))
          0:       d = month_len(y, m);
          1:       d = month_len(y, m) + 1;
          default: d = 0;
        endcase
      end else begin
        m = $urandom_range(15, 0);
        d = $urandom_range(31, 0);
      end
      send_date(make_row(y, m, d));
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (facts_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
